// ----- hdl/poi_pkg.sv -----
// ----------------------------------------------------------------------------
// poi_pkg - shared types and constants of the planar odometry integrator
// Fixed-point widths, CORDIC angle table, configuration indexes and the
// command word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package poi_pkg;

	// Widths of the state and of the channel fields
	localparam int ANGLE_BITS    = 16;
	localparam int POSITION_BITS = 32;
	localparam int TIME_W        = 16;
	localparam int VEL_W         = 24;
	localparam int YAW_W         = 16;
	localparam int POSE_POS_W    = 32;
	localparam int POSE_HDG_W    = 16;

	// CORDIC sizing: Q2.30 vectors with headroom, 32-bit turn angle plus guard
	localparam int CORDIC_STEPS = 24;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 34;
	localparam int ZW           = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	// Product and scaling widths
	localparam int PROD_W = VEL_W + CW;
	localparam int SUM_W  = PROD_W + 1;
	localparam int WV_W   = 42;
	localparam int SCL_W  = WV_W + TIME_W + 1;
	localparam int DPOS_W = SCL_W - 32;
	localparam int DTH_PW = YAW_W + TIME_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_FORWARD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_LATERAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_RATE    = 2'd2;

	localparam logic signed [VEL_W-1:0] VEL_FORWARD_RST = 24'sd6554;
	localparam logic signed [VEL_W-1:0] VEL_LATERAL_RST = -24'sd6554;
	localparam logic signed [YAW_W-1:0] YAW_RATE_RST    = 16'sd1043;

	// Datapath operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
	localparam logic [OP_W-1:0] OP_ROT    = 3'd2;
	localparam logic [OP_W-1:0] OP_PRODX  = 3'd3;
	localparam logic [OP_W-1:0] OP_PRODY  = 3'd4;
	localparam logic [OP_W-1:0] OP_WY     = 3'd5;
	localparam logic [OP_W-1:0] OP_SCALE  = 3'd6;
	localparam logic [OP_W-1:0] OP_UPDATE = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	// Arctangent of 2^-i as a 32-bit turn fraction
	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340244;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ----- hdl/poi_tick_if.sv -----
// ----------------------------------------------------------------------------
// poi_tick_if - odometry tick channel
// Carries the elapsed time of one tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface poi_tick_if;
	logic                       valid;
	logic                       ready;
	logic [poi_pkg::TIME_W-1:0] elapsed_time;

	modport source (output valid, output elapsed_time, input ready);
	modport sink (input valid, input elapsed_time, output ready);
endinterface

// ----- hdl/poi_pose_if.sv -----
// ----------------------------------------------------------------------------
// poi_pose_if - pose result channel
// Carries the updated position and heading with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface poi_pose_if;
	logic                           valid;
	logic                           ready;
	logic [poi_pkg::POSE_POS_W-1:0] pose_x;
	logic [poi_pkg::POSE_POS_W-1:0] pose_y;
	logic [poi_pkg::POSE_HDG_W-1:0] pose_heading;

	modport source (output valid, output pose_x, output pose_y, output pose_heading,
		input ready);
	modport sink (input valid, input pose_x, input pose_y, input pose_heading,
		output ready);
endinterface

// ----- hdl/poi_cfg_if.sv -----
// ----------------------------------------------------------------------------
// poi_cfg_if - configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface poi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [poi_pkg::CFG_IDX_W-1:0]  index;
	logic [poi_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/poi_ctrl.sv -----
// ----------------------------------------------------------------------------
// poi_ctrl - sequencer of the odometry integrator
// Steps the datapath through load, CORDIC rotation, products, scaling and
// pose update, and owns the valid flag of the pose output register.
// ----------------------------------------------------------------------------
module poi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick_valid,
	output logic          tick_ready,
	output logic          pose_valid,
	input  logic          pose_ready,
	output poi_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ROT    = 3'd1;
	localparam logic [2:0] S_PRODX  = 3'd2;
	localparam logic [2:0] S_PRODY  = 3'd3;
	localparam logic [2:0] S_WY     = 3'd4;
	localparam logic [2:0] S_SCALE  = 3'd5;
	localparam logic [2:0] S_UPDATE = 3'd6;

	localparam logic [poi_pkg::ITER_W-1:0] LAST_ITER =
		poi_pkg::ITER_W'(poi_pkg::CORDIC_STEPS - 1);

	logic [2:0]                   state_q, state_d;
	logic [poi_pkg::ITER_W-1:0]   iter_q, iter_d;
	logic                         full_q, full_d;
	logic                         do_update;

	assign tick_ready = (state_q == S_IDLE);
	assign pose_valid = full_q;
	// Result register may be refilled when empty or drained this cycle
	assign do_update  = (state_q == S_UPDATE) && (!full_q || pose_ready);

	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd.op   = poi_pkg::OP_NOP;
		cmd.iter = iter_q;
		unique case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					cmd.op  = poi_pkg::OP_LOAD;
					iter_d  = '0;
					state_d = S_ROT;
				end
			end
			S_ROT: begin
				cmd.op = poi_pkg::OP_ROT;
				if (iter_q == LAST_ITER) begin
					state_d = S_PRODX;
				end else begin
					iter_d = iter_q + 1'b1;
				end
			end
			S_PRODX: begin
				cmd.op  = poi_pkg::OP_PRODX;
				state_d = S_PRODY;
			end
			S_PRODY: begin
				cmd.op  = poi_pkg::OP_PRODY;
				state_d = S_WY;
			end
			S_WY: begin
				cmd.op  = poi_pkg::OP_WY;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.op  = poi_pkg::OP_SCALE;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (do_update) begin
					cmd.op  = poi_pkg::OP_UPDATE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign full_d = do_update || (full_q && !pose_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
			full_q  <= full_d;
		end
	end

endmodule

// ----- hdl/poi_dp.sv -----
// ----------------------------------------------------------------------------
// poi_dp - datapath of the odometry integrator
// Holds configuration, pose state, an iterative CORDIC unit, two shared
// multipliers, the saturating position adders and the pose output register.
// ----------------------------------------------------------------------------
module poi_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  poi_pkg::cmd_t                      cmd,
	input  logic [poi_pkg::TIME_W-1:0]         elapsed_time,
	input  logic                               cfg_we,
	input  logic [poi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [poi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic [poi_pkg::POSE_POS_W-1:0]     pose_x,
	output logic [poi_pkg::POSE_POS_W-1:0]     pose_y,
	output logic [poi_pkg::POSE_HDG_W-1:0]     pose_heading
);

	localparam int POS_W = poi_pkg::POSITION_BITS;
	localparam int ANG_W = poi_pkg::ANGLE_BITS;
	localparam int SP_W  = ((POS_W > poi_pkg::DPOS_W) ? POS_W : poi_pkg::DPOS_W) + 1;
	localparam logic signed [SP_W-1:0] POS_HI = SP_W'({1'b0, {(POS_W-1){1'b1}}});
	localparam logic signed [SP_W-1:0] POS_LO = -POS_HI - SP_W'(1);

	// Configuration and pose state
	logic signed [poi_pkg::VEL_W-1:0] vel_fwd_q, vel_lat_q;
	logic signed [poi_pkg::YAW_W-1:0] yaw_q;
	logic signed [POS_W-1:0]          pos_x_q, pos_y_q;
	logic [ANG_W-1:0]                 heading_q;

	// Working registers of one tick
	logic [poi_pkg::TIME_W-1:0]        t_q;
	logic signed [poi_pkg::CW-1:0]     x_q, y_q;
	logic signed [poi_pkg::ZW-1:0]     z_q;
	logic                              flip_q;
	logic signed [poi_pkg::PROD_W-1:0] pa_q, pb_q;
	logic signed [poi_pkg::WV_W-1:0]   wx_q, wy_q;
	logic signed [poi_pkg::SCL_W-1:0]  ma_q, mb_q;
	logic signed [poi_pkg::DPOS_W-1:0] dx_q;
	logic [ANG_W-1:0]                  dth_q;
	logic [poi_pkg::POSE_POS_W-1:0]    pose_x_q, pose_y_q;
	logic [poi_pkg::POSE_HDG_W-1:0]    pose_hdg_q;

	// Combinational
	logic [31:0]                       u, u_rot;
	logic                              load_flip;
	logic signed [poi_pkg::ZW-1:0]     z_init, at_s;
	logic signed [poi_pkg::CW-1:0]     xs, ys;
	logic signed [poi_pkg::PROD_W-1:0] mul_a, mul_b;
	logic signed [poi_pkg::SUM_W-1:0]  sum_x, sum_y, sh_x, sh_y;
	logic signed [poi_pkg::TIME_W:0]   t_s;
	logic signed [poi_pkg::SCL_W-1:0]  scl_in, scl_out, scl_x, scl_y;
	logic signed [poi_pkg::DTH_PW-1:0] dth_p;
	logic signed [poi_pkg::DPOS_W-1:0] dy;
	logic signed [SP_W-1:0]            nx_sum, ny_sum;
	logic signed [POS_W-1:0]           pos_x_d, pos_y_d;
	logic [ANG_W-1:0]                  heading_d;

	// Fold the heading into the right half plane
	assign u         = 32'(heading_q) << (32 - ANG_W);
	assign load_flip = u[31] ^ u[30];
	assign u_rot     = {u[31] ^ load_flip, u[30:0]};
	assign z_init    = poi_pkg::ZW'(signed'(u_rot));

	assign xs   = x_q >>> cmd.iter;
	assign ys   = y_q >>> cmd.iter;
	assign at_s = signed'(poi_pkg::ZW'(poi_pkg::atan_turn(cmd.iter)));

	// Shared multipliers: X products first, then Y products
	always_comb begin
		if (cmd.op == poi_pkg::OP_PRODX) begin
			mul_a = vel_fwd_q * x_q;
			mul_b = vel_lat_q * y_q;
		end else begin
			mul_a = vel_fwd_q * y_q;
			mul_b = vel_lat_q * x_q;
		end
	end

	// World velocity: c, s negated when the angle was folded
	always_comb begin
		sum_x = flip_q ? (poi_pkg::SUM_W'(pb_q) - poi_pkg::SUM_W'(pa_q))
			: (poi_pkg::SUM_W'(pa_q) - poi_pkg::SUM_W'(pb_q));
		sum_y = poi_pkg::SUM_W'(pa_q) + poi_pkg::SUM_W'(pb_q);
		if (flip_q) begin
			sum_y = -sum_y;
		end
		sh_x = (sum_x + poi_pkg::SUM_W'(8192)) >>> 14;
		sh_y = (sum_y + poi_pkg::SUM_W'(8192)) >>> 14;
	end

	// Time scaling multiplier, one per cycle
	assign t_s     = signed'({1'b0, t_q});
	assign scl_in  = (cmd.op == poi_pkg::OP_WY) ? poi_pkg::SCL_W'(wx_q)
		: poi_pkg::SCL_W'(wy_q);
	assign scl_out = scl_in * t_s;
	assign dth_p   = yaw_q * t_s;

	assign scl_x = (ma_q + poi_pkg::SCL_W'(64'sh8000_0000)) >>> 32;
	assign scl_y = (mb_q + poi_pkg::SCL_W'(64'sh8000_0000)) >>> 32;
	assign dy    = poi_pkg::DPOS_W'(scl_y);

	// Saturating position update
	always_comb begin
		nx_sum = SP_W'(pos_x_q) + SP_W'(dx_q);
		ny_sum = SP_W'(pos_y_q) + SP_W'(dy);
		priority if (nx_sum > POS_HI) begin
			pos_x_d = POS_W'(POS_HI);
		end else if (nx_sum < POS_LO) begin
			pos_x_d = POS_W'(POS_LO);
		end else begin
			pos_x_d = POS_W'(nx_sum);
		end
		priority if (ny_sum > POS_HI) begin
			pos_y_d = POS_W'(POS_HI);
		end else if (ny_sum < POS_LO) begin
			pos_y_d = POS_W'(POS_LO);
		end else begin
			pos_y_d = POS_W'(ny_sum);
		end
		heading_d = heading_q + dth_q;
	end

	// Configuration and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_fwd_q <= poi_pkg::VEL_FORWARD_RST;
			vel_lat_q <= poi_pkg::VEL_LATERAL_RST;
			yaw_q     <= poi_pkg::YAW_RATE_RST;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					poi_pkg::CFG_VEL_FORWARD: vel_fwd_q <= signed'(cfg_wdata);
					poi_pkg::CFG_VEL_LATERAL: vel_lat_q <= signed'(cfg_wdata);
					poi_pkg::CFG_YAW_RATE:
						yaw_q <= signed'(cfg_wdata[poi_pkg::YAW_W-1:0]);
					default: ;
				endcase
			end
			if (cmd.op == poi_pkg::OP_UPDATE) begin
				pos_x_q   <= pos_x_d;
				pos_y_q   <= pos_y_d;
				heading_q <= heading_d;
			end
		end
	end

	// Working registers, stepped by the controller
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			poi_pkg::OP_LOAD: begin
				t_q    <= elapsed_time;
				x_q    <= poi_pkg::CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= z_init;
				flip_q <= load_flip;
			end
			poi_pkg::OP_ROT: begin
				if (!z_q[poi_pkg::ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at_s;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at_s;
				end
			end
			poi_pkg::OP_PRODX: begin
				pa_q <= mul_a;
				pb_q <= mul_b;
			end
			poi_pkg::OP_PRODY: begin
				wx_q <= poi_pkg::WV_W'(sh_x);
				pa_q <= mul_a;
				pb_q <= mul_b;
			end
			poi_pkg::OP_WY: begin
				wy_q  <= poi_pkg::WV_W'(sh_y);
				ma_q  <= scl_out;
				dth_q <= ANG_W'(signed'((dth_p + poi_pkg::DTH_PW'(32768)) >>> 16));
			end
			poi_pkg::OP_SCALE: begin
				mb_q <= scl_out;
				dx_q <= poi_pkg::DPOS_W'(scl_x);
			end
			poi_pkg::OP_UPDATE: begin
				pose_x_q   <= poi_pkg::POSE_POS_W'(pos_x_d);
				pose_y_q   <= poi_pkg::POSE_POS_W'(pos_y_d);
				pose_hdg_q <= poi_pkg::POSE_HDG_W'(heading_d);
			end
			default: ;
		endcase
	end

	assign pose_x       = pose_x_q;
	assign pose_y       = pose_y_q;
	assign pose_heading = pose_hdg_q;

endmodule

// ----- hdl/planar_odometry_integrator.sv -----
// ----------------------------------------------------------------------------
// planar_odometry_integrator - 2D dead-reckoning pose integrator
// Rotates the body velocity by the heading (iterative CORDIC), scales it by
// the tick time, adds it to a saturating Q16.16 position and advances the
// binary-angle heading by yaw rate times tick time.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | beat contents
//  --------+-----+---------------+-------------------------------------------
//  tick    | in  | valid / ready | elapsed_time (Q0.16 s)
//  pose    | out | valid / ready | pose_x, pose_y (Q16.16 m), pose_heading
//  cfg     | in  | valid / ready | index, wdata (vel_forward, vel_lateral,
//          |     |               | yaw_rate; unknown index ignored)
//
// The accept edge loads the working registers, then 24 CORDIC steps, the two
// velocity products, the time products and the pose update follow: the pose
// beat is registered by the update, and the next tick is taken after it.
// The pose sits in an output register, so the next tick is accepted while it
// waits; the next update stalls only while that beat is still not taken.
// Reset (arst_n low) clears the pose state and loads the default registers.
//
module planar_odometry_integrator (
	input  logic      clk,
	input  logic      arst_n,
	poi_tick_if.sink  tick,
	poi_pose_if.source pose,
	poi_cfg_if.sink   cfg
);

	poi_pkg::cmd_t cmd;
	logic          cfg_we;

	// Configuration writes are always accepted
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// Sequence the tick through the datapath
	poi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick.ready),
		.pose_valid (pose.valid),
		.pose_ready (pose.ready),
		.cmd        (cmd)
	);

	// Hold state, run CORDIC and multipliers, register the pose beat
	poi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.elapsed_time (tick.elapsed_time),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg.index),
		.cfg_wdata    (cfg.wdata),
		.pose_x       (pose.pose_x),
		.pose_y       (pose.pose_y),
		.pose_heading (pose.pose_heading)
	);

endmodule

// ----- bench/pose_check_pkg.sv -----
// ----------------------------------------------------------------------------
// pose_check_pkg - pose tracker for the planar odometry integrator bench
// Keeps its own copy of the velocity and yaw registers and of the pose,
// integrates every accepted tick and checks the pose beats in order.
// ----------------------------------------------------------------------------
package pose_check_pkg;
	import poi_pkg::*;

	typedef struct packed {
		logic [POSE_POS_W-1:0] x;
		logic [POSE_POS_W-1:0] y;
		logic [POSE_HDG_W-1:0] hdg;
	} pose_t;

	class pose_tracker;
		longint                vel_fwd;
		longint                vel_lat;
		longint                yaw;
		longint                pos_x;
		longint                pos_y;
		logic [ANGLE_BITS-1:0] hdg;
		pose_t                 expected[$];
		int                    errors;
		int                    checked;
		int                    ticks;
		int                    zero_ticks;
		int                    clipped;
		int                    writes;

		function new();
			vel_fwd    = $signed(VEL_FORWARD_RST);
			vel_lat    = $signed(VEL_LATERAL_RST);
			yaw        = $signed(YAW_RATE_RST);
			pos_x      = 0;
			pos_y      = 0;
			hdg        = '0;
			errors     = 0;
			checked    = 0;
			ticks      = 0;
			zero_ticks = 0;
			clipped    = 0;
			writes     = 0;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 20) begin
				$display("mismatch: %s", msg);
			end
		endtask

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
			writes++;
			case (idx)
				CFG_VEL_FORWARD: vel_fwd = $signed(data[VEL_W-1:0]);
				CFG_VEL_LATERAL: vel_lat = $signed(data[VEL_W-1:0]);
				CFG_YAW_RATE:    yaw = $signed(data[YAW_W-1:0]);
				default: ;
			endcase
		endfunction

		// Rotate the gain vector by the heading; results in Q2.30
		function void sin_cos(input logic [ANGLE_BITS-1:0] ang, output longint c,
			output longint s);
			longint      arc [24] = '{
				536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340244, 2670163, 1335087, 667544, 333772,
				166886, 83443, 41722, 20861, 10430, 5215,
				2608, 1304, 652, 326, 163, 81};
			logic [31:0] u;
			bit          flip;
			longint      x;
			longint      y;
			longint      z;
			longint      nx;
			u    = {ang, {(32 - ANGLE_BITS){1'b0}}};
			flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
			if (flip) begin
				u = u + 32'h8000_0000;
			end
			z = $signed(u);
			x = 652032874;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y  = y + (x >>> i);
					z  = z - arc[i];
				end else begin
					nx = x + (y >>> i);
					y  = y - (x >>> i);
					z  = z + arc[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint clip_add(input longint p, input longint d);
			longint hi;
			longint lo;
			longint r;
			hi = (longint'(1) << (POSITION_BITS - 1)) - 1;
			lo = -hi - 1;
			r  = p + d;
			if (r > hi) begin
				clipped++;
				return hi;
			end
			if (r < lo) begin
				clipped++;
				return lo;
			end
			return r;
		endfunction

		function void note_tick(input logic [TIME_W-1:0] t);
			longint tt;
			longint c;
			longint s;
			longint wx;
			longint wy;
			longint dx;
			longint dy;
			longint dth;
			pose_t  p;
			tt = t;
			ticks++;
			if (t == 0) begin
				zero_ticks++;
			end
			sin_cos(hdg, c, s);
			wx    = (vel_fwd * c - vel_lat * s + 8192) >>> 14;
			wy    = (vel_fwd * s + vel_lat * c + 8192) >>> 14;
			dx    = (wx * tt + (longint'(1) << 31)) >>> 32;
			dy    = (wy * tt + (longint'(1) << 31)) >>> 32;
			pos_x = clip_add(pos_x, dx);
			pos_y = clip_add(pos_y, dy);
			dth   = (yaw * tt + 32768) >>> 16;
			hdg   = hdg + dth[ANGLE_BITS-1:0];
			p.x   = pos_x[POSE_POS_W-1:0];
			p.y   = pos_y[POSE_POS_W-1:0];
			p.hdg = hdg;
			expected.push_back(p);
		endfunction

		task check_pose(input logic [POSE_POS_W-1:0] x, input logic [POSE_POS_W-1:0] y,
			input logic [POSE_HDG_W-1:0] h);
			pose_t want;
			if (expected.size() == 0) begin
				report($sformatf("pose beat x=%h y=%h hdg=%h with no tick pending", x, y, h));
				return;
			end
			want = expected.pop_front();
			checked++;
			if (x !== want.x) begin
				report($sformatf("beat %0d pose_x got %h want %h", checked, x, want.x));
			end
			if (y !== want.y) begin
				report($sformatf("beat %0d pose_y got %h want %h", checked, y, want.y));
			end
			if (h !== want.hdg) begin
				report($sformatf("beat %0d pose_heading got %h want %h", checked, h, want.hdg));
			end
		endtask
	endclass

endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of the planar odometry integrator
// Drives ticks and register writes, tracks the expected pose per tick and
// checks every pose beat in order, under three idle patterns on the channels.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import poi_pkg::*;
	import pose_check_pkg::*;

	localparam int PERIOD      = 10;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;

	// Index that maps to no register; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [VEL_W-1:0] VEL_MAX = 24'h7F_FFFF;
	localparam logic [VEL_W-1:0] VEL_MIN = 24'h80_0000;
	localparam logic [YAW_W-1:0] YAW_MAX = 16'h7FFF;
	localparam logic [YAW_W-1:0] YAW_MIN = 16'h8000;

	logic clk = 1'b0;
	logic arst_n;

	poi_tick_if tick ();
	poi_pose_if pose ();
	poi_cfg_if  cfg ();

	planar_odometry_integrator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.pose   (pose),
		.cfg    (cfg)
	);

	pose_tracker track;

	// Idle percentages per channel and the burst flags that switch idling off
	int src_pct;
	int snk_pct;
	bit src_burst;
	bit snk_burst;
	int snk_cycle;
	int quiet;

	always #(PERIOD / 2) clk = ~clk;

	// Sample all three channels at the rising edge. Check the pose first: a
	// tick accepted on the same edge can never belong to that beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				track.write_reg(cfg.index, cfg.wdata);
			end
			if (pose.valid && pose.ready) begin
				track.check_pose(pose.pose_x, pose.pose_y, pose.pose_heading);
			end
			if (tick.valid && tick.ready) begin
				track.note_tick(tick.elapsed_time);
			end
		end
	end

	// Watchdog: count edges with no beat on any channel, give up at the limit
	always @(posedge clk) begin
		if (!arst_n || (tick.valid && tick.ready) || (pose.valid && pose.ready)
			|| (cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d poses outstanding", quiet,
				track.expected.size());
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Pose receiver: stall at random; snk_cycle paces the re-roll of the no-stall burst
	always @(negedge clk) begin
		if (!arst_n) begin
			pose.ready <= 1'b0;
		end else begin
			snk_cycle = snk_cycle + 1;
			if (snk_cycle % 50 == 0) begin
				snk_burst = ($urandom_range(5) == 0);
			end
			pose.ready <= snk_burst || ($urandom_range(99) >= snk_pct);
		end
	end

	task automatic set_mode(input int mode);
		case (mode)
			0: begin
				src_pct = 15;
				snk_pct = 88;
			end
			1: begin
				src_pct = 88;
				snk_pct = 15;
			end
			default: begin
				src_pct = 0;
				snk_pct = 0;
			end
		endcase
	endtask

	// Call at a falling edge; returns at the falling edge after the beat with
	// valid still high, so back-to-back ticks need no extra assignment.
	task automatic send_tick(input logic [TIME_W-1:0] t);
		if (!src_burst) begin
			while ($urandom_range(99) < src_pct) begin
				tick.valid <= 1'b0;
				@(negedge clk);
			end
		end
		tick.valid        <= 1'b1;
		tick.elapsed_time <= t;
		@(posedge clk);
		while (!tick.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Same calling rule as send_tick; load_regs drops valid after the batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= data;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Write all registers; the yaw write carries junk in the unused upper byte
	task automatic load_regs(input logic [VEL_W-1:0] vf, input logic [VEL_W-1:0] vl,
		input logic [YAW_W-1:0] yaw);
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(CFG_VEL_FORWARD, vf);
		write_reg(CFG_VEL_LATERAL, vl);
		write_reg(CFG_YAW_RATE, {8'($urandom), yaw});
		cfg.valid <= 1'b0;
	endtask

	// Drop the tick valid and hold until every pose beat has come back
	task automatic wait_idle();
		tick.valid <= 1'b0;
		while (track.expected.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Sprint phases favor long ticks so the position runs into its limits
	function automatic logic [TIME_W-1:0] pick_time(input bit sprint);
		if (sprint) begin
			if ($urandom_range(3) != 0) begin
				return TIME_W'($urandom_range(65535, 40000));
			end
			return TIME_W'($urandom);
		end
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return TIME_W'($urandom_range(255));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int mode, input logic [VEL_W-1:0] vf,
		input logic [VEL_W-1:0] vl, input logic [YAW_W-1:0] yaw, input int count,
		input bit sprint);
		wait_idle();
		set_mode(mode);
		load_regs(vf, vl, yaw);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				src_burst = ($urandom_range(5) == 0);
			end
			send_tick(pick_time(sprint));
		end
	endtask

	function automatic logic [VEL_W-1:0] slow_vel();
		return VEL_W'(int'($urandom_range(13108)) - 6554);
	endfunction

	initial begin
		track     = new();
		arst_n    = 1'b0;
		src_pct   = 0;
		snk_pct   = 0;
		src_burst = 1'b0;
		snk_burst = 1'b0;
		snk_cycle = 0;
		quiet     = 0;
		tick.valid        = 1'b0;
		tick.elapsed_time = '0;
		pose.ready        = 1'b0;
		cfg.valid         = 1'b0;
		cfg.index         = '0;
		cfg.wdata         = '0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset registers, zero time first so the reset pose comes back
		set_mode(0);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h0001);
		send_tick(16'h8000);
		send_tick(16'h0000);

		// Directed: velocity and yaw extremes; long ticks swing the heading
		// by nearly half a turn each, zero time repeats the pose
		wait_idle();
		load_regs(VEL_MAX, VEL_MIN, YAW_MAX);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		send_tick(16'h5555);
		send_tick(16'hAAAA);
		send_tick(16'h0000);

		wait_idle();
		load_regs(VEL_MIN, VEL_MAX, YAW_MIN);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		send_tick(16'hFFFF);
		send_tick(16'h0001);
		send_tick(16'h7FFF);

		// Random: three idle patterns, each over several register settings;
		// zero yaw in the sprints keeps the heading fixed so the position clips
		run_phase(0, VEL_MAX, VEL_MIN, YAW_MAX, 200, 1'b0);
		run_phase(0, VEL_MAX, VEL_MAX, '0, 300, 1'b1);
		run_phase(0, VEL_W'($urandom), VEL_W'($urandom), YAW_W'($urandom), 200, 1'b0);
		run_phase(1, VEL_MIN, VEL_MAX, YAW_MIN, 200, 1'b0);
		run_phase(1, VEL_MIN, VEL_MIN, '0, 300, 1'b1);
		run_phase(1, '0, '0, YAW_W'($urandom), 200, 1'b0);
		run_phase(2, VEL_W'($urandom), VEL_W'($urandom), YAW_W'($urandom), 200, 1'b0);
		run_phase(2, VEL_MAX, VEL_MAX, '0, 300, 1'b1);
		run_phase(2, slow_vel(), slow_vel(), YAW_W'($urandom_range(2047)), 200, 1'b0);

		// Drain, then give stray beats time to show up
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (track.expected.size() != 0) begin
			track.report($sformatf("%0d poses never arrived", track.expected.size()));
		end

		$display("run: %0d ticks, %0d pose beats checked, %0d zero-time ticks, %0d clipped axes",
			track.ticks, track.checked, track.zero_ticks, track.clipped);
		$display("run: %0d register writes, three idle patterns, %0d mismatches",
			track.writes, track.errors);
		if (track.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/poi_pkg.sv
hdl/poi_tick_if.sv
hdl/poi_pose_if.sv
hdl/poi_cfg_if.sv
hdl/poi_ctrl.sv
hdl/poi_dp.sv
hdl/planar_odometry_integrator.sv
bench/pose_check_pkg.sv
bench/tb_top.sv
